>>> src/rbst_pkg.sv
// ----------------------------------------------------------------------------
// Ray box slab test package
// Shared widths, register codes and the exact-rational candidate type.
// ----------------------------------------------------------------------------
package rbst_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_AXES    = 3;

    // A slab parameter is num / den with den positive.
    localparam int NUM_W  = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * NUM_W;

    localparam int PDATA_W  = (COORD_WIDTH > 32) ? 64 : 32;
    localparam int ADDR_LSB = (COORD_WIDTH > 32) ? 3 : 2;
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W  = ADDR_LSB + REG_IDX_W;

    localparam int IN_FIELDS   = 8;
    localparam int IN_TDATA_W  = ((IN_FIELDS * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    localparam logic [COORD_WIDTH-1:0] ONE_FIX = COORD_WIDTH'(1) << FRAC_BITS;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic                   valid;
        logic [NUM_W-1:0]       num;
        logic [COORD_WIDTH-1:0] den;
    } t_cand;

    typedef struct packed {
        logic [NUM_AXES-1:0][COORD_WIDTH-1:0] org;
        logic [NUM_AXES-1:0][COORD_WIDTH-1:0] dir;
    } t_ray;

    function automatic t_cand fixed_to_cand(input logic [COORD_WIDTH-1:0] v);
        t_cand c;
        c.valid = 1'b1;
        c.num   = NUM_W'($signed(v));
        c.den   = ONE_FIX;
        return c;
    endfunction

endpackage

>>> src/ray_box_slab_test_unit.sv
// ----------------------------------------------------------------------------
// Ray box slab test unit
// Throughput: one item per cycle while the output is not stalled; nine register stages with valid bits.
// A stalled output holds only the stages that are full; bubbles still fill.
// Reset clears the stage valid bits and sets the ray to origin 0, direction +x.
// ----------------------------------------------------------------------------
module ray_box_slab_test_unit
    import rbst_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0 up: box_x_low, box_x_high, box_y_low, box_y_high,
    // box_z_low, box_z_high, t_start, t_end.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Fields from bit 0 up: hit, then zero padding.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    localparam int N_STG   = 9;
    localparam int S_DIFF  = 0;
    localparam int S_ORDER = 1;
    localparam int S_L1M   = 2;
    localparam int S_L1S   = 3;
    localparam int S_L2M   = 4;
    localparam int S_L2S   = 5;
    localparam int S_FM    = 6;
    localparam int S_FS    = 7;
    localparam int S_OUT   = 8;

    t_ray ray;

    logic [N_STG-1:0] r_v;
    logic [N_STG-1:0] en;

    logic [COORD_WIDTH-1:0] r_ts1;
    logic [COORD_WIDTH-1:0] r_te1;
    logic [COORD_WIDTH-1:0] r_ts2;
    logic [COORD_WIDTH-1:0] r_te2;

    t_cand [NUM_AXES-1:0] near;
    t_cand [NUM_AXES-1:0] far;
    logic  [NUM_AXES-1:0] fail;

    t_cand lo_a;
    t_cand lo_b;
    t_cand up_a;
    t_cand up_b;
    t_cand tmin;
    t_cand tmax;
    t_cand fin_res;
    logic  lo_a_gt;
    logic  lo_b_gt;
    logic  up_a_gt;
    logic  up_b_gt;
    logic  tmin_gt;
    logic  tmax_gt;
    logic  fin_gt;

    logic [S_FS:S_L1M] r_miss;
    logic              r_hit;

    rbst_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_ray   (ray)
    );

    always_comb begin
        en[S_OUT] = !r_v[S_OUT] || m_axis_tready;
        for (int k = S_OUT - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[S_DIFF];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[S_DIFF]) begin
                r_v[S_DIFF] <= s_axis_tvalid;
            end
            for (int k = 1; k < N_STG; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        rbst_slab_axis u_axis (
            .i_clk      (i_clk),
            .i_en_diff  (en[S_DIFF]),
            .i_en_order (en[S_ORDER]),
            .i_low      (s_axis_tdata[(2*a)*COORD_WIDTH +: COORD_WIDTH]),
            .i_high     (s_axis_tdata[(2*a+1)*COORD_WIDTH +: COORD_WIDTH]),
            .i_org      (ray.org[a]),
            .i_dir      (ray.dir[a]),
            .o_near     (near[a]),
            .o_far      (far[a]),
            .o_fail     (fail[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en[S_DIFF]) begin
            r_ts1 <= s_axis_tdata[6*COORD_WIDTH +: COORD_WIDTH];
            r_te1 <= s_axis_tdata[7*COORD_WIDTH +: COORD_WIDTH];
        end
        if (en[S_ORDER]) begin
            r_ts2 <= r_ts1;
            r_te2 <= r_te1;
        end
    end

    // The lower end is the largest of t_start and the entry parameters,
    // the upper end the smallest of t_end and the exit parameters.
    rbst_rat_cmp u_lo_a (
        .i_clk (i_clk), .i_en_mul (en[S_L1M]), .i_en_sel (en[S_L1S]),
        .i_take_max (1'b1), .i_a (fixed_to_cand(r_ts2)), .i_b (near[0]),
        .o_res (lo_a), .o_a_gt_b (lo_a_gt)
    );

    rbst_rat_cmp u_lo_b (
        .i_clk (i_clk), .i_en_mul (en[S_L1M]), .i_en_sel (en[S_L1S]),
        .i_take_max (1'b1), .i_a (near[1]), .i_b (near[2]),
        .o_res (lo_b), .o_a_gt_b (lo_b_gt)
    );

    rbst_rat_cmp u_up_a (
        .i_clk (i_clk), .i_en_mul (en[S_L1M]), .i_en_sel (en[S_L1S]),
        .i_take_max (1'b0), .i_a (fixed_to_cand(r_te2)), .i_b (far[0]),
        .o_res (up_a), .o_a_gt_b (up_a_gt)
    );

    rbst_rat_cmp u_up_b (
        .i_clk (i_clk), .i_en_mul (en[S_L1M]), .i_en_sel (en[S_L1S]),
        .i_take_max (1'b0), .i_a (far[1]), .i_b (far[2]),
        .o_res (up_b), .o_a_gt_b (up_b_gt)
    );

    rbst_rat_cmp u_tmin (
        .i_clk (i_clk), .i_en_mul (en[S_L2M]), .i_en_sel (en[S_L2S]),
        .i_take_max (1'b1), .i_a (lo_a), .i_b (lo_b),
        .o_res (tmin), .o_a_gt_b (tmin_gt)
    );

    rbst_rat_cmp u_tmax (
        .i_clk (i_clk), .i_en_mul (en[S_L2M]), .i_en_sel (en[S_L2S]),
        .i_take_max (1'b0), .i_a (up_a), .i_b (up_b),
        .o_res (tmax), .o_a_gt_b (tmax_gt)
    );

    rbst_rat_cmp u_final (
        .i_clk (i_clk), .i_en_mul (en[S_FM]), .i_en_sel (en[S_FS]),
        .i_take_max (1'b1), .i_a (tmax), .i_b (tmin),
        .o_res (fin_res), .o_a_gt_b (fin_gt)
    );

    always_ff @(posedge i_clk) begin
        if (en[S_L1M]) begin
            r_miss[S_L1M] <= |fail;
        end
        for (int k = S_L1M + 1; k <= S_FS; k++) begin
            if (en[k]) begin
                r_miss[k] <= r_miss[k-1];
            end
        end
        if (en[S_OUT]) begin
            r_hit <= !r_miss[S_FS] && fin_gt && fin_res.valid
                     && !(lo_a_gt && lo_b_gt && up_a_gt && up_b_gt
                          && tmin_gt && tmax_gt && 1'b0);
        end
    end

    assign m_axis_tvalid = r_v[S_OUT];
    assign m_axis_tdata  = OUT_TDATA_W'(r_hit);

endmodule

>>> src/rbst_cfg_regs.sv
// ----------------------------------------------------------------------------
// Ray configuration registers
// APB-style register file holding the ray origin and direction.
// ----------------------------------------------------------------------------
module rbst_cfg_regs
    import rbst_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_ray               o_ray
);

    t_ray                 r_ray;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;
    logic [COORD_WIDTH-1:0] wval;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[PADDR_W-1:ADDR_LSB];
    assign wval   = pwdata[COORD_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray.org <= '0;
            r_ray.dir <= (NUM_AXES*COORD_WIDTH)'(ONE_FIX);
        end else if (wr_en) begin
            case (t_reg_idx'(idx))
                REG_ORIGIN_X: r_ray.org[0] <= wval;
                REG_ORIGIN_Y: r_ray.org[1] <= wval;
                REG_ORIGIN_Z: r_ray.org[2] <= wval;
                REG_DIR_X:    r_ray.dir[0] <= wval;
                REG_DIR_Y:    r_ray.dir[1] <= wval;
                REG_DIR_Z:    r_ray.dir[2] <= wval;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(idx))
            REG_ORIGIN_X: prdata = PDATA_W'($signed(r_ray.org[0]));
            REG_ORIGIN_Y: prdata = PDATA_W'($signed(r_ray.org[1]));
            REG_ORIGIN_Z: prdata = PDATA_W'($signed(r_ray.org[2]));
            REG_DIR_X:    prdata = PDATA_W'($signed(r_ray.dir[0]));
            REG_DIR_Y:    prdata = PDATA_W'($signed(r_ray.dir[1]));
            REG_DIR_Z:    prdata = PDATA_W'($signed(r_ray.dir[2]));
            default:      prdata = '0;
        endcase
    end

    assign o_ray = r_ray;

endmodule

>>> src/rbst_slab_axis.sv
// ----------------------------------------------------------------------------
// Slab parameter stage
// Two pipeline stages that form the ordered entry and exit parameters of
// one axis as exact rationals, plus the zero-direction pass check.
// ----------------------------------------------------------------------------
module rbst_slab_axis
    import rbst_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_en_diff,
    input  logic                   i_en_order,
    input  logic [COORD_WIDTH-1:0] i_low,
    input  logic [COORD_WIDTH-1:0] i_high,
    input  logic [COORD_WIDTH-1:0] i_org,
    input  logic [COORD_WIDTH-1:0] i_dir,
    output t_cand                  o_near,
    output t_cand                  o_far,
    output logic                   o_fail
);

    logic signed [NUM_W-1:0] r_d0;
    logic signed [NUM_W-1:0] r_d1;
    logic [COORD_WIDTH-1:0]  r_den;
    logic                    r_neg;
    logic                    r_zero;

    logic signed [NUM_W-1:0] n_d0;
    logic signed [NUM_W-1:0] n_d1;
    logic signed [NUM_W-1:0] num0;
    logic signed [NUM_W-1:0] num1;
    logic                    lt;
    logic                    take0;

    t_cand r_near;
    t_cand r_far;
    logic  r_fail;

    assign n_d0 = NUM_W'($signed(i_low))  - NUM_W'($signed(i_org));
    assign n_d1 = NUM_W'($signed(i_high)) - NUM_W'($signed(i_org));

    always_ff @(posedge i_clk) begin
        if (i_en_diff) begin
            r_d0   <= n_d0;
            r_d1   <= n_d1;
            r_neg  <= i_dir[COORD_WIDTH-1];
            r_zero <= (i_dir == '0);
            r_den  <= i_dir[COORD_WIDTH-1] ? (COORD_WIDTH'(0) - i_dir) : i_dir;
        end
    end

    // A negative direction flips the sign of both parameters and so their order.
    assign num0  = r_neg ? -r_d0 : r_d0;
    assign num1  = r_neg ? -r_d1 : r_d1;
    assign lt    = (r_d0 < r_d1);
    assign take0 = lt ^ r_neg;

    always_ff @(posedge i_clk) begin
        if (i_en_order) begin
            r_near.valid <= !r_zero;
            r_near.num   <= take0 ? num0 : num1;
            r_near.den   <= r_den;
            r_far.valid  <= !r_zero;
            r_far.num    <= take0 ? num1 : num0;
            r_far.den    <= r_den;
            r_fail       <= r_zero && !((r_d0 < 0) && (r_d1 > 0));
        end
    end

    assign o_near = r_near;
    assign o_far  = r_far;
    assign o_fail = r_fail;

endmodule

>>> src/rbst_rat_cmp.sv
// ----------------------------------------------------------------------------
// Rational compare and select
// Two pipeline stages: cross products, then exact compare and selection of
// the larger or smaller valid candidate.
// ----------------------------------------------------------------------------
module rbst_rat_cmp
    import rbst_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en_mul,
    input  logic  i_en_sel,
    input  logic  i_take_max,
    input  t_cand i_a,
    input  t_cand i_b,
    output t_cand o_res,
    output logic  o_a_gt_b
);

    t_cand                    r_a;
    t_cand                    r_b;
    logic signed [PROD_W-1:0] r_pa;
    logic signed [PROD_W-1:0] r_pb;

    logic signed [PROD_W-1:0] n_pa;
    logic signed [PROD_W-1:0] n_pb;
    logic                     gt;
    t_cand                    n_res;

    t_cand r_res;
    logic  r_gt;

    assign n_pa = PROD_W'($signed(i_a.num)) * PROD_W'($signed({1'b0, i_b.den}));
    assign n_pb = PROD_W'($signed(i_b.num)) * PROD_W'($signed({1'b0, i_a.den}));

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_pa <= n_pa;
            r_pb <= n_pb;
        end
    end

    assign gt = (r_pa > r_pb);

    always_comb begin
        if (!r_a.valid) begin
            n_res = r_b;
        end else if (!r_b.valid) begin
            n_res = r_a;
        end else if (i_take_max) begin
            n_res = gt ? r_a : r_b;
        end else begin
            n_res = gt ? r_b : r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sel) begin
            r_res <= n_res;
            r_gt  <= gt;
        end
    end

    assign o_res    = r_res;
    assign o_a_gt_b = r_gt;

endmodule

>>> sim/tb_ray_box_slab_test_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the ray box slab test unit
// Programs the ray over the APB-style port, streams boxes with parameter
// intervals through the input port with random gaps and output stalls, and
// checks every hit flag against a probe-table entry or an exact-rational slab test kept in the bench.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_test_unit;

    import rbst_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct {
        t_coord lo [NUM_AXES];
        t_coord hi [NUM_AXES];
        t_coord t_start;
        t_coord t_end;
    } t_box_query;

    // Slab parameter as an exact fraction, den always positive.
    typedef struct {
        logic signed [127:0] num;
        logic signed [127:0] den;
    } t_frac;

    localparam t_coord C_ONE = t_coord'(ONE_FIX);
    localparam t_coord C_MIN = 32'sh8000_0000;
    localparam t_coord C_MAX = 32'sh7fff_ffff;

    localparam t_coord EXP_MISS    = 0;
    localparam t_coord EXP_HIT     = 1;
    localparam t_coord EXP_PREDICT = -1;

    localparam logic [REG_IDX_W-1:0] SPARE_REG_A = 3'd6;
    localparam logic [REG_IDX_W-1:0] SPARE_REG_B = 3'd7;

    localparam int PROBE_ROWS   = 17;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 112;
    localparam int HOLD_OFF_CYC = 400;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // Fields from bit 0 up: box_x_low, box_x_high, box_y_low, box_y_high,
    // box_z_low, box_z_high, t_start, t_end.
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // Fields from bit 0 up: hit, then zero padding.
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    t_coord ray_org [NUM_AXES];
    t_coord ray_dir [NUM_AXES];

    bit expected_hits [$];
    int error_count;
    bit send_idle;
    bit recv_idle;
    bit hold_off_req;

    // Columns: x low, x high, y low, y high, z low, z high, t_start, t_end, expected.
    t_coord probe_rows [PROBE_ROWS][9] = '{
        '{C_ONE, 2*C_ONE, -C_ONE, C_ONE, -C_ONE, C_ONE, 0, 10*C_ONE, EXP_HIT},
        '{C_ONE, 2*C_ONE, 0, C_ONE, -C_ONE, C_ONE, 0, 10*C_ONE, EXP_MISS},
        '{C_ONE, 2*C_ONE, -C_ONE, C_ONE, -C_ONE, C_ONE, 5*C_ONE, 5*C_ONE, EXP_MISS},
        '{2*C_ONE, C_ONE, -C_ONE, C_ONE, -C_ONE, C_ONE, 0, 10*C_ONE, EXP_HIT},
        '{C_ONE, 2*C_ONE, -C_ONE, C_ONE, -C_ONE, C_ONE, 0, C_ONE, EXP_MISS},
        '{C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, EXP_HIT},
        '{C_ONE, 2*C_ONE, C_ONE, -C_ONE, -C_ONE, C_ONE, 0, 10*C_ONE, EXP_MISS},
        '{0, 0, 0, 0, 0, 0, 0, 0, EXP_MISS},
        '{C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, EXP_MISS},
        '{-2*C_ONE, -C_ONE, -C_ONE, C_ONE, -C_ONE, C_ONE, 0, 10*C_ONE, EXP_MISS},
        '{-2*C_ONE, -C_ONE, -C_ONE, C_ONE, -C_ONE, C_ONE, C_MIN, C_MAX, EXP_HIT},
        '{C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, EXP_PREDICT},
        '{C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, EXP_PREDICT},
        '{-1, 1, -1, 1, -1, 1, -1, 1, EXP_HIT},
        '{0, C_ONE, C_MIN, -1, C_MIN, C_MAX, C_MIN, C_MAX, EXP_PREDICT},
        '{C_ONE, 2*C_ONE, -C_ONE, C_ONE, -C_ONE, C_ONE, 2*C_ONE, 3*C_ONE, EXP_MISS},
        '{C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, EXP_MISS}
    };

    ray_box_slab_test_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic t_frac fixed_frac(input t_coord v);
        t_frac f;
        f.num = v;
        f.den = 128'sd1 <<< FRAC_BITS;
        return f;
    endfunction

    function automatic t_frac slab_frac(input t_coord bound, input t_coord org,
                                        input t_coord dir);
        t_frac f;
        f.num = bound;
        f.num = f.num - org;
        f.den = dir;
        if (dir < 0) begin
            f.num = -f.num;
            f.den = -f.den;
        end
        return f;
    endfunction

    function automatic int frac_cmp(input t_frac a, input t_frac b);
        logic signed [127:0] lhs;
        logic signed [127:0] rhs;
        lhs = a.num * b.den;
        rhs = b.num * a.den;
        return (lhs < rhs) ? -1 : ((lhs > rhs) ? 1 : 0);
    endfunction

    function automatic bit predict_hit(input t_box_query q);
        t_frac t_min;
        t_frac t_max;
        t_frac near_t;
        t_frac far_t;
        t_min = fixed_frac(q.t_start);
        t_max = fixed_frac(q.t_end);
        for (int a = 0; a < NUM_AXES; a++) begin
            if (ray_dir[a] == 0) begin
                if (!(q.lo[a] < ray_org[a] && ray_org[a] < q.hi[a])) begin
                    return 1'b0;
                end
            end else begin
                near_t = slab_frac(q.lo[a], ray_org[a], ray_dir[a]);
                far_t  = slab_frac(q.hi[a], ray_org[a], ray_dir[a]);
                if (frac_cmp(near_t, far_t) >= 0) begin
                    near_t = far_t;
                    far_t  = slab_frac(q.lo[a], ray_org[a], ray_dir[a]);
                end
                if (frac_cmp(near_t, t_min) > 0) begin
                    t_min = near_t;
                end
                if (frac_cmp(far_t, t_max) < 0) begin
                    t_max = far_t;
                end
            end
            if (frac_cmp(t_max, t_min) <= 0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input t_coord value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << ADDR_LSB;
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (t_reg_idx'(idx))
            REG_ORIGIN_X: ray_org[0] = value;
            REG_ORIGIN_Y: ray_org[1] = value;
            REG_ORIGIN_Z: ray_org[2] = value;
            REG_DIR_X:    ray_dir[0] = value;
            REG_DIR_Y:    ray_dir[1] = value;
            REG_DIR_Z:    ray_dir[2] = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic offer_box(input t_box_query q, input t_coord exp_code);
        int gap;
        gap = send_idle ? $urandom_range(0, 14) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {q.t_end, q.t_start, q.hi[2], q.lo[2], q.hi[1], q.lo[1],
                          q.hi[0], q.lo[0]};
        do @(posedge i_clk); while (!s_axis_tready);
        if (exp_code == EXP_PREDICT) begin
            expected_hits.push_back(predict_hit(q));
        end else begin
            expected_hits.push_back(exp_code == EXP_HIT);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_coord small_signed(input int span);
        int v;
        v = $urandom_range(0, 2 * span);
        return t_coord'(v - span);
    endfunction

    function automatic t_coord edge_coord();
        case ($urandom_range(0, 5))
            0: return C_MIN;
            1: return C_MAX;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_box_query random_query();
        t_box_query q;
        t_coord c;
        t_coord swap_tmp;
        int mode;
        mode = $urandom_range(0, 9);
        for (int a = 0; a < NUM_AXES; a++) begin
            if (mode < 6) begin
                // Box placed around the ray origin, so the slab test gets deep.
                c = ray_org[a] + small_signed(1 << 18);
                q.lo[a] = c - t_coord'($urandom_range(0, 1 << 19));
                q.hi[a] = c + t_coord'($urandom_range(0, 1 << 19));
                if ($urandom_range(0, 9) == 0) begin
                    swap_tmp = q.lo[a];
                    q.lo[a]  = q.hi[a];
                    q.hi[a]  = swap_tmp;
                end
            end else if (mode < 8) begin
                q.lo[a] = t_coord'($urandom);
                q.hi[a] = t_coord'($urandom);
            end else begin
                q.lo[a] = edge_coord();
                q.hi[a] = edge_coord();
            end
        end
        if (mode < 6) begin
            q.t_start = -t_coord'($urandom_range(0, 1 << 22));
            q.t_end   = t_coord'($urandom_range(0, 1 << 22));
            if ($urandom_range(0, 9) == 0) begin
                swap_tmp  = q.t_start;
                q.t_start = q.t_end;
                q.t_end   = swap_tmp;
            end
        end else if (mode < 8) begin
            q.t_start = t_coord'($urandom);
            q.t_end   = t_coord'($urandom);
        end else begin
            q.t_start = edge_coord();
            q.t_end   = edge_coord();
        end
        return q;
    endfunction

    function automatic t_coord random_dir();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return small_signed(1 << 17);
            2: return t_coord'($urandom);
            default: return ($urandom_range(0, 1) == 1) ? C_ONE : -C_ONE;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_hits.size() == 0) begin
                flag_mismatch($sformatf("unexpected result, hit=%0b", m_axis_tdata[0]));
            end else begin
                if (m_axis_tdata[0] !== expected_hits[0]) begin
                    flag_mismatch($sformatf("hit got %0b expected %0b",
                                            m_axis_tdata[0], expected_hits[0]));
                end
                void'(expected_hits.pop_front());
            end
        end
    end

    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = recv_idle ? $urandom_range(0, 14) : 0;
            if (hold_off_req) begin
                gap          = HOLD_OFF_CYC;
                hold_off_req = 1'b0;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        #(12 * 300000);
        $display("tb_ray_box_slab_test_unit NOT OK");
        $finish;
    end

    initial begin
        t_box_query q;
        t_coord     org_pick;
        t_coord     dir_pick;
        error_count   = 0;
        send_idle     = 1'b1;
        recv_idle     = 1'b1;
        hold_off_req  = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            ray_org[a] = 0;
            ray_dir[a] = 0;
        end
        ray_dir[0] = C_ONE;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PROBE_ROWS; r++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                q.lo[a] = probe_rows[r][2*a];
                q.hi[a] = probe_rows[r][2*a+1];
            end
            q.t_start = probe_rows[r][6];
            q.t_end   = probe_rows[r][7];
            offer_box(q, probe_rows[r][8]);
        end
        drain_results();

        // Writes to unused register slots must leave the ray untouched.
        apb_write(SPARE_REG_A, t_coord'($urandom));
        apb_write(SPARE_REG_B, t_coord'($urandom));

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                case (phase)
                    0: begin
                        org_pick = C_MIN;
                        dir_pick = C_MAX;
                    end
                    1: begin
                        org_pick = C_MAX;
                        dir_pick = C_MIN;
                    end
                    2: begin
                        org_pick = small_signed(1 << 20);
                        dir_pick = 0;
                    end
                    default: begin
                        org_pick = ($urandom_range(0, 1) == 1) ? small_signed(1 << 20)
                                                                : t_coord'($urandom);
                        dir_pick = random_dir();
                    end
                endcase
                apb_write(t_reg_idx'(REG_ORIGIN_X + a), org_pick);
                apb_write(t_reg_idx'(REG_DIR_X + a), dir_pick);
            end
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            if (phase == 3) begin
                send_idle    = 1'b0;
                hold_off_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                offer_box(random_query(), EXP_PREDICT);
            end
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_ray_box_slab_test_unit OK");
        end else begin
            $display("tb_ray_box_slab_test_unit NOT OK");
        end
        $finish;
    end

endmodule

>>> ray_box_slab_test_unit.f
src/rbst_pkg.sv
src/rbst_cfg_regs.sv
src/rbst_slab_axis.sv
src/rbst_rat_cmp.sv
src/ray_box_slab_test_unit.sv
sim/tb_ray_box_slab_test_unit.sv
